[sv/frp_pkg.sv]
// ----------------------------------------------------------------------------
// frp_pkg: shared definitions for the FIFO page replacement block
// Widths, reset values, register indexes, controller states and the
// control group that the controller sends to the frame memory.
// ----------------------------------------------------------------------------
package frp_pkg;

	localparam int FRAMES_DEF = 8;
	localparam int PAGE_W     = 8;
	localparam int CNT_W      = 16;
	localparam int CFG_W      = 4;
	localparam int APB_DW     = 32;
	localparam int APB_AW     = 3;

	localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 4'd3;
	localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};

	// Register index as decoded from paddr[APB_AW-1:2].
	localparam logic REG_FRAME_COUNT = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic re;
		logic we;
	} mem_ctl_t;

endpackage

[sv/frp_mem.sv]
// ----------------------------------------------------------------------------
// frp_mem: frame page store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module frp_mem #(
	parameter int FRAMES = frp_pkg::FRAMES_DEF,
	parameter int PTR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                      clk,
	input  frp_pkg::mem_ctl_t         mem_ctl,
	input  logic [PTR_W-1:0]          raddr,
	input  logic [PTR_W-1:0]          waddr,
	input  logic [frp_pkg::PAGE_W-1:0] wdata,
	output logic [frp_pkg::PAGE_W-1:0] rdata
);

	logic [frp_pkg::PAGE_W-1:0] mem_q [FRAMES];
	logic [frp_pkg::PAGE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_ctl.we) begin
			mem_q[waddr] <= wdata;
		end
		if (mem_ctl.re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/frp_ctrl.sv]
// ----------------------------------------------------------------------------
// frp_ctrl: search and update sequencer
// Frames are kept as a circular buffer in the frame memory: head_q is the
// oldest page. Each reference is compared against the resident pages one
// memory read per cycle, then the totals and result are updated and, on a miss, the buffer.
// ----------------------------------------------------------------------------
module frp_ctrl #(
	parameter int FRAMES = frp_pkg::FRAMES_DEF,
	parameter int PTR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [frp_pkg::CFG_W-1:0]    frame_count,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [frp_pkg::PAGE_W-1:0]   page_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         evict_valid,
	output logic [frp_pkg::PAGE_W-1:0]   evicted_page,
	output logic [frp_pkg::CNT_W-1:0]    hit_total,
	output logic [frp_pkg::CNT_W-1:0]    miss_total,
	output frp_pkg::mem_ctl_t            mem_ctl,
	output logic [PTR_W-1:0]             raddr,
	output logic [PTR_W-1:0]             waddr,
	output logic [frp_pkg::PAGE_W-1:0]   wdata,
	input  logic [frp_pkg::PAGE_W-1:0]   rdata
);

	localparam int OCC_W = $clog2(FRAMES + 1);
	localparam int SUM_W = ((OCC_W > PTR_W) ? OCC_W : PTR_W) + 1;
	localparam int LIM_W = (OCC_W > frp_pkg::CFG_W) ? OCC_W : frp_pkg::CFG_W;

	frp_pkg::state_t state_q, state_d;

	logic [frp_pkg::PAGE_W-1:0] page_q;
	logic [OCC_W-1:0]           occ_q;
	logic [PTR_W-1:0]           head_q;
	logic [OCC_W-1:0]           scan_q;
	logic                       found_q;
	logic [frp_pkg::PAGE_W-1:0] victim_q;
	logic [frp_pkg::CNT_W-1:0]  hit_cnt_q;
	logic [frp_pkg::CNT_W-1:0]  miss_cnt_q;

	logic                       out_valid_q;
	logic                       hit_q;
	logic                       evict_q;
	logic [frp_pkg::PAGE_W-1:0] evicted_q;

	logic             accept;
	logic             out_free;
	logic             match;
	logic             last;
	logic             evict;
	logic             fin_load;
	logic [LIM_W-1:0] lim;
	logic [OCC_W-1:0] scan_nxt;

	// Circular pointer add; the base is below FRAMES and the offset at most
	// FRAMES, so one conditional subtract wraps the sum.
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
		input logic [OCC_W-1:0] off);
		logic [SUM_W-1:0] s;
		s = SUM_W'(base) + SUM_W'(off);
		if (s >= SUM_W'(FRAMES)) begin
			s = s - SUM_W'(FRAMES);
		end
		return s[PTR_W-1:0];
	endfunction

	always_comb begin
		if (frame_count == '0) begin
			lim = LIM_W'(1);
		end else if (LIM_W'(frame_count) > LIM_W'(FRAMES)) begin
			lim = LIM_W'(FRAMES);
		end else begin
			lim = LIM_W'(frame_count);
		end
	end

	assign accept   = in_valid && (state_q == frp_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign match    = (rdata == page_q);
	assign scan_nxt = scan_q + OCC_W'(1);
	assign last     = (scan_nxt == occ_q);
	assign evict    = (LIM_W'(occ_q) >= lim);
	assign fin_load = (state_q == frp_pkg::ST_FIN) && out_free;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			frp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (occ_q == '0) ? frp_pkg::ST_FIN : frp_pkg::ST_SCAN;
				end
			end
			frp_pkg::ST_SCAN: begin
				if (match || last) begin
					state_d = frp_pkg::ST_FIN;
				end
			end
			frp_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = frp_pkg::ST_IDLE;
				end
			end
			default: state_d = frp_pkg::ST_IDLE;
		endcase
	end

	// Memory control and handshake outputs. The next read is issued while
	// the current word is compared; the write happens only in the final
	// state, so no read of the same item can overlap it.
	always_comb begin
		mem_ctl.re = 1'b0;
		mem_ctl.we = 1'b0;
		raddr      = head_q;
		in_stall   = 1'b1;
		unique case (state_q)
			frp_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				mem_ctl.re = in_valid;
			end
			frp_pkg::ST_SCAN: begin
				mem_ctl.re = !match && !last;
				raddr      = ptr_add(head_q, scan_nxt);
			end
			frp_pkg::ST_FIN: begin
				mem_ctl.we = out_free && !found_q;
			end
			default: begin
				mem_ctl.re = 1'b0;
			end
		endcase
	end

	// The new page always goes just past the newest one; on an eviction the
	// head then moves on, so the set keeps its size.
	assign waddr = ptr_add(head_q, occ_q);
	assign wdata = page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frp_pkg::ST_IDLE;
			occ_q       <= '0;
			head_q      <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fin_load) begin
				if (found_q) begin
					if (hit_cnt_q != frp_pkg::CNT_MAX) begin
						hit_cnt_q <= hit_cnt_q + frp_pkg::CNT_W'(1);
					end
				end else begin
					if (miss_cnt_q != frp_pkg::CNT_MAX) begin
						miss_cnt_q <= miss_cnt_q + frp_pkg::CNT_W'(1);
					end
					if (evict) begin
						head_q <= ptr_add(head_q, OCC_W'(1));
					end else begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q  <= page_id;
			scan_q  <= '0;
			found_q <= 1'b0;
		end
		if (state_q == frp_pkg::ST_SCAN) begin
			// The first word read is the oldest page, the eviction candidate.
			if (scan_q == '0) begin
				victim_q <= rdata;
			end
			if (match) begin
				found_q <= 1'b1;
			end
			scan_q <= scan_nxt;
		end
		if (fin_load) begin
			hit_q     <= found_q;
			evict_q   <= !found_q && evict;
			evicted_q <= (!found_q && evict) ? victim_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign evict_valid  = evict_q;
	assign evicted_page = evicted_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		OCC_W'(FRAMES) >= occ_q)
		else $error("occupancy exceeds the number of frames");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == frp_pkg::ST_SCAN) |-> (scan_q < occ_q))
		else $error("search index passed the resident pages");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("new transaction accepted while one is in progress");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_load && found_q) |=> ((hit_cnt_q == $past(hit_cnt_q) + frp_pkg::CNT_W'(1))
		|| (hit_cnt_q == frp_pkg::CNT_MAX)) && $stable(miss_cnt_q) && $stable(occ_q))
		else $error("hit did not advance only the hit total");

endmodule

[sv/fifo_page_replacement.sv]
// ----------------------------------------------------------------------------
// fifo_page_replacement: FIFO page replacement with running hit/miss totals
// One transaction at a time: in_stall stays high from acceptance until its result
//   is loaded into the output register. The search compares 1..occupancy resident
//   pages (none when no page is resident); the frame memory has one read port, so the
//   search reads one resident page per cycle.
// Reset clears occupancy, head pointer and totals and sets frame_count to 3;
//   frame memory contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_page_replacement #(
	parameter int FRAMES = frp_pkg::FRAMES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [frp_pkg::APB_AW-1:0]   paddr,
	input  logic [frp_pkg::APB_DW-1:0]   pwdata,
	output logic [frp_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [frp_pkg::PAGE_W-1:0]   page_id,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         evict_valid,
	output logic [frp_pkg::PAGE_W-1:0]   evicted_page,
	output logic [frp_pkg::CNT_W-1:0]    hit_total,
	output logic [frp_pkg::CNT_W-1:0]    miss_total
);

	localparam int PTR_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	logic [frp_pkg::CFG_W-1:0]  frame_count_q;
	logic                       reg_idx;
	frp_pkg::mem_ctl_t          mem_ctl;
	logic [PTR_W-1:0]           raddr;
	logic [PTR_W-1:0]           waddr;
	logic [frp_pkg::PAGE_W-1:0] wdata;
	logic [frp_pkg::PAGE_W-1:0] rdata;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= frp_pkg::FRAME_COUNT_RST;
		end else if (psel && penable && pwrite && (reg_idx == frp_pkg::REG_FRAME_COUNT)) begin
			frame_count_q <= pwdata[frp_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == frp_pkg::REG_FRAME_COUNT) begin
			prdata = frp_pkg::APB_DW'(frame_count_q);
		end
	end

	frp_ctrl #(
		.FRAMES (FRAMES),
		.PTR_W  (PTR_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_count  (frame_count_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_id      (page_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.evict_valid  (evict_valid),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.miss_total   (miss_total),
		.mem_ctl      (mem_ctl),
		.raddr        (raddr),
		.waddr        (waddr),
		.wdata        (wdata),
		.rdata        (rdata)
	);

	frp_mem #(
		.FRAMES (FRAMES),
		.PTR_W  (PTR_W)
	) u_mem (
		.clk     (clk),
		.mem_ctl (mem_ctl),
		.raddr   (raddr),
		.waddr   (waddr),
		.wdata   (wdata),
		.rdata   (rdata)
	);

endmodule

[tb/sv/tb_fifo_page_replacement.sv]
// ----------------------------------------------------------------------------
// tb_fifo_page_replacement: self-checking bench for the FIFO page replacement
// Drives page references and frame_count writes. A scoreboard keeps its own
// copy of the resident frames and totals and compares every result
// transaction field by field, under random idling, a long output hold-off
// and limits below occupancy.
// ----------------------------------------------------------------------------
module tb_fifo_page_replacement;

	localparam int NUM_FRAMES  = frp_pkg::FRAMES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTS  = 40;
	localparam logic [frp_pkg::APB_AW-1:0] ADDR_FRAME_COUNT =
		frp_pkg::APB_AW'(4 * int'(frp_pkg::REG_FRAME_COUNT));
	localparam logic [frp_pkg::APB_AW-1:0] ADDR_UNMAPPED =
		frp_pkg::APB_AW'(4 * (int'(frp_pkg::REG_FRAME_COUNT) + 1));

	typedef struct packed {
		logic                        hit;
		logic                        evict_valid;
		logic [frp_pkg::PAGE_W-1:0]  evicted_page;
		logic [frp_pkg::CNT_W-1:0]   hit_total;
		logic [frp_pkg::CNT_W-1:0]   miss_total;
	} page_result_t;

	class page_scoreboard;
		logic [frp_pkg::PAGE_W-1:0] frames [NUM_FRAMES];
		int                         occupancy;
		logic [frp_pkg::CNT_W-1:0]  hit_count;
		logic [frp_pkg::CNT_W-1:0]  miss_count;
		logic [frp_pkg::CFG_W-1:0]  frame_count;
		page_result_t               expected_q[$];
		int                         errors;
		int                         refs_noted;
		int                         results_checked;

		function new();
			occupancy = 0;
			hit_count = '0;
			miss_count = '0;
			frame_count = frp_pkg::FRAME_COUNT_RST;
			errors = 0;
			refs_noted = 0;
			results_checked = 0;
		endfunction

		function void write_reg(int index, logic [frp_pkg::APB_DW-1:0] value);
			if (index == int'(frp_pkg::REG_FRAME_COUNT)) begin
				frame_count = value[frp_pkg::CFG_W-1:0];
			end
		endfunction

		// Zero behaves as one frame, anything above the frame array as all of it.
		function int frame_limit();
			int lim;
			lim = int'(frame_count);
			if (lim < 1) begin
				lim = 1;
			end
			if (lim > NUM_FRAMES) begin
				lim = NUM_FRAMES;
			end
			return lim;
		endfunction

		function void note_page(logic [frp_pkg::PAGE_W-1:0] page);
			page_result_t r;
			int           lim;
			bit           found;
			lim = frame_limit();
			found = 0;
			r = '0;
			for (int i = 0; i < occupancy; i++) begin
				if (frames[i] == page) begin
					found = 1;
				end
			end
			if (found) begin
				r.hit = 1'b1;
				if (hit_count != frp_pkg::CNT_MAX) begin
					hit_count = hit_count + 1'b1;
				end
			end else begin
				if (miss_count != frp_pkg::CNT_MAX) begin
					miss_count = miss_count + 1'b1;
				end
				// A lowered limit never shrinks the resident set: one out, one in.
				if (occupancy >= lim) begin
					r.evict_valid = 1'b1;
					r.evicted_page = frames[0];
					for (int i = 1; i < occupancy; i++) begin
						frames[i-1] = frames[i];
					end
					frames[occupancy-1] = page;
				end else begin
					frames[occupancy] = page;
					occupancy++;
				end
			end
			r.hit_total = hit_count;
			r.miss_total = miss_count;
			expected_q.push_back(r);
			refs_noted++;
		endfunction

		task report(string what);
			if (errors < MAX_PRINTS) begin
				$display("MISMATCH: %s", what);
			end
			errors++;
		endtask

		task check_result(page_result_t got);
			page_result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("result transaction with nothing expected: %h", got));
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (got.hit !== want.hit) begin
				report($sformatf("result %0d hit %b, expected %b",
					results_checked, got.hit, want.hit));
			end
			if (got.evict_valid !== want.evict_valid) begin
				report($sformatf("result %0d evict_valid %b, expected %b",
					results_checked, got.evict_valid, want.evict_valid));
			end
			if (got.evicted_page !== want.evicted_page) begin
				report($sformatf("result %0d evicted_page %0d, expected %0d",
					results_checked, got.evicted_page, want.evicted_page));
			end
			if (got.hit_total !== want.hit_total) begin
				report($sformatf("result %0d hit_total %0d, expected %0d",
					results_checked, got.hit_total, want.hit_total));
			end
			if (got.miss_total !== want.miss_total) begin
				report($sformatf("result %0d miss_total %0d, expected %0d",
					results_checked, got.miss_total, want.miss_total));
			end
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [frp_pkg::APB_AW-1:0]    paddr = '0;
	logic [frp_pkg::APB_DW-1:0]    pwdata = '0;
	logic [frp_pkg::APB_DW-1:0]    prdata;
	logic                          pready;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [frp_pkg::PAGE_W-1:0]    page_id = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic                          hit;
	logic                          evict_valid;
	logic [frp_pkg::PAGE_W-1:0]    evicted_page;
	logic [frp_pkg::CNT_W-1:0]     hit_total;
	logic [frp_pkg::CNT_W-1:0]     miss_total;

	page_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int cycles = 0;
	int settings_used = 0;

	fifo_page_replacement dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page_id      (page_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.evict_valid  (evict_valid),
		.evicted_page (evicted_page),
		.hit_total    (hit_total),
		.miss_total   (miss_total)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycles, sb.expected_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: check what was accepted at this edge, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result({hit, evict_valid, evicted_page, hit_total, miss_total});
		end
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Each cycle the sender may sit idle before offering the page.
	task send_page(input logic [frp_pkg::PAGE_W-1:0] p);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		page_id <= p;
		do @(posedge clk); while (in_stall);
		sb.note_page(p);
	endtask

	task drain_results();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task apb_write(input logic [frp_pkg::APB_AW-1:0] addr,
		input logic [frp_pkg::APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(int'(addr) / 4, data);
		@(posedge clk);
	endtask

	task apb_read_check();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_FRAME_COUNT;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[frp_pkg::CFG_W-1:0] !== sb.frame_count) begin
			sb.report($sformatf("frame_count read %0d, expected %0d",
				prdata[frp_pkg::CFG_W-1:0], sb.frame_count));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Upper write-data bits are junk; only the low nibble is the register.
	task set_frame_count(input logic [frp_pkg::CFG_W-1:0] fc);
		logic [frp_pkg::APB_DW-1:0] data;
		drain_results();
		data = $urandom();
		data[frp_pkg::CFG_W-1:0] = fc;
		apb_write(ADDR_FRAME_COUNT, data);
		apb_read_check();
		settings_used++;
	endtask

	task run_segment(input int n, input logic [frp_pkg::CFG_W-1:0] fc, input bit hold,
		input bit pause);
		int                         lim;
		logic [frp_pkg::PAGE_W-1:0] base;
		logic [frp_pkg::PAGE_W-1:0] p;
		int                         pick;
		set_frame_count(fc);
		lim = sb.frame_limit();
		base = $urandom();
		for (int i = 0; i < n; i++) begin
			if (hold && i == n / 4) begin
				hold_request = 120;
			end
			if (pause && i == n / 2) begin
				drain_results();
			end
			if (i % 35 == 34) begin
				base = $urandom();
			end
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				p = base + frp_pkg::PAGE_W'($urandom_range(0, lim + lim / 2));
			end else if (pick < 90 && sb.occupancy > 0) begin
				p = sb.frames[$urandom_range(0, sb.occupancy - 1)];
			end else begin
				p = $urandom();
			end
			send_page(p);
		end
	endtask

	task run_phase(input int s_pct, input int r_pct, input int first);
		logic [frp_pkg::CFG_W-1:0] fc_plan [12];
		fc_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8, 4'd3, 4'd12, 4'd1,
			frp_pkg::CFG_W'($urandom_range(0, 15)), frp_pkg::CFG_W'($urandom_range(0, 15))};
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int s = 0; s < 4; s++) begin
			run_segment(70, fc_plan[first + s], (first == 0 && s == 1), (first == 4 && s == 0));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value first, then short directed sequences with no idling.
		apb_read_check();
		send_page(8'd0);
		send_page(8'd255);
		send_page(8'd0);
		send_page(8'd170);
		send_page(8'd85);
		send_page(8'd255);
		send_page(8'd0);
		set_frame_count(4'd8);
		send_page(8'd1);
		send_page(8'd2);
		send_page(8'd4);
		send_page(8'd8);
		send_page(8'd16);
		send_page(8'd128);
		// Limit below occupancy: old pages still hit and a miss swaps one page.
		set_frame_count(4'd2);
		send_page(8'd85);
		send_page(8'd200);
		send_page(8'd16);
		set_frame_count(4'd0);
		send_page(8'd201);
		set_frame_count(4'd15);
		send_page(8'd202);
		drain_results();
		apb_write(ADDR_UNMAPPED, 32'h0000_0005);
		apb_read_check();
		send_page(8'd203);

		run_phase(34, 64, 0);
		run_phase(64, 34, 4);
		run_phase(0, 0, 8);

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d page references, %0d results checked, %0d frame_count writes,",
			sb.refs_noted, sb.results_checked, settings_used);
		$display("including full frames, limits below occupancy and a long output hold-off.");
		if (sb.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
